FILE: rtl/core/chained_hash_table_defines.svh
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
// assertion helpers
`ifndef NO_ASSERTIONS
`define CHT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CHT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CHT_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define CHT_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/core/cht_pkg.sv
package cht_pkg;
    localparam int MAX_BUCKETS_DEF  = 256;
    localparam int POOL_ENTRIES_DEF = 256;
    localparam int KEY_BITS_DEF     = 32;
    localparam int VALUE_BITS_DEF   = 32;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
endpackage

FILE: rtl/core/chained_hash_table.sv
// chained hash table: insert / lookup / remove over a fixed entry pool
// request channel i_valid/o_ready carries command, key and value; the
// result channel o_valid/i_ready carries found_value, found, status and
// table_empty, one result per request
// one request is handled at a time; o_ready is low from acceptance until
// the result has been taken
// insert reads the bucket head, then the free-list head, then writes the new
// entry and the bucket head, ending after the head read when the pool is full;
// lookup and remove read the bucket head, then read and compare each chain
// entry in turn, with an extra unlink step for removing an entry behind the
// chain head; both memories have a registered read on a separate read port
// after reset, and after every write of min_buckets, a clearing pass writes
// every bucket head to empty and relinks the pool as a free list, one entry
// a cycle; no request is taken meanwhile
// a stalled result holds in its output registers until i_ready is high
// bucket count is min_buckets rounded up to a power of two, 2 to
// MAX_BUCKETS; a newer duplicate key shadows the older one
`include "chained_hash_table_defines.svh"
module chained_hash_table import cht_pkg::*; #(
    parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_found_value,
    output logic        o_found,
    output logic [1:0]  o_status,
    output logic        o_table_empty
);
    localparam int BW   = (MAX_BUCKETS > 2) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PW   = $clog2(POOL_ENTRIES);
    localparam int LW   = PW + 1;                // link width, nil = POOL_ENTRIES
    localparam int CLRN = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
    localparam int CW   = $clog2(CLRN + 1);
    localparam int KW   = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int EW   = KW + VW + LW;
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);
    localparam logic [BW:0]   BMAX = (BW+1)'(1) << $clog2(MAX_BUCKETS + 1) - 1;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HEAD   = 4'd2;
    localparam logic [3:0] S_HEADW  = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_RDW    = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_FREE   = 4'd7;
    localparam logic [3:0] S_FREEW  = 4'd8;
    localparam logic [3:0] S_INS    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_UNLINK = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_clr, n_clr;
    logic [BW-1:0] r_mask;
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_cmd;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [BW-1:0] r_bkt;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_steps, n_steps;
    logic          r_ovalid, n_ovalid;
    logic [31:0]   r_fval, n_fval;
    logic          r_found, n_found;
    logic [1:0]    r_stat, n_stat;

    // bucket head memory
    logic          bh_we;
    logic [BW-1:0] bh_waddr, bh_raddr;
    logic [LW-1:0] bh_wdata, bh_rdata;
    // entry memory {key, value, next}
    logic          en_we;
    logic [PW-1:0] en_waddr, en_raddr;
    logic [EW-1:0] en_wdata, en_rdata;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_val;
    logic [LW-1:0] rd_next;

    cht_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(bh_we), .i_waddr(bh_waddr), .i_wdata(bh_wdata),
        .i_raddr(bh_raddr), .o_rdata(bh_rdata));
    cht_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_entries (
        .i_clk(i_clk), .i_we(en_we), .i_waddr(en_waddr), .i_wdata(en_wdata),
        .i_raddr(en_raddr), .o_rdata(en_rdata));

    assign {rd_key, rd_val, rd_next} = en_rdata;

    function automatic logic [LW-1:0] link_ok(input logic [LW-1:0] x);
        return (x < NIL) ? x : NIL;
    endfunction

    // bucket mask from requested size, saturating at largest power of two
    function automatic logic [BW-1:0] mask_of(input logic [8:0] req);
        logic [BW:0] n;
        logic [9:0]  rq;
        n  = (BW+1)'(2);
        rq = (req == 9'd0) ? 10'd1 : {1'b0, req};
        for (int i = 0; i < BW; i++) begin
            if ((BW+11)'(n) < (BW+11)'(rq) && n < BMAX) n = n << 1;
        end
        return BW'(n - (BW+1)'(1));
    endfunction

    // key and value written into the new entry by an insert
    logic [KW-1:0] ins_key;
    logic [VW-1:0] ins_val;

    // saved key/value of the previous and current chain entries
    logic [KW-1:0] r_pkey, r_ckey;
    logic [VW-1:0] r_pval, r_cval;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_free   = r_free;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_ovalid = r_ovalid;
        n_fval   = r_fval;
        n_found  = r_found;
        n_stat   = r_stat;
        bh_we    = 1'b0;
        bh_waddr = r_bkt;
        bh_wdata = NIL;
        bh_raddr = r_bkt;
        en_we    = 1'b0;
        en_waddr = r_cur[PW-1:0];
        en_wdata = {rd_key, rd_val, rd_next};
        en_raddr = r_cur[PW-1:0];
        ins_key  = r_key;
        ins_val  = r_val;
        case (r_state)
            S_CLEAR: begin
                bh_we    = (r_clr < CW'(MAX_BUCKETS));
                bh_waddr = r_clr[BW-1:0];
                bh_wdata = NIL;
                en_we    = (r_clr < CW'(POOL_ENTRIES));
                en_waddr = r_clr[PW-1:0];
                en_wdata = {KW'(0), VW'(0), LW'(r_clr) + LW'(1)};
                n_clr    = r_clr + CW'(1);
                if (r_clr == CW'(CLRN - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && o_ready) n_state = S_HEAD;
            end
            S_HEAD: n_state = S_HEADW;
            S_HEADW: begin
                n_cur   = link_ok(bh_rdata);
                n_prev  = NIL;
                n_steps = '0;
                if (r_cmd == CMD_INSERT) begin
                    if (r_free == NIL) begin
                        n_stat  = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FREE;
                    end
                end else if (r_cmd == CMD_LOOKUP || r_cmd == CMD_REMOVE) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                en_raddr = r_free[PW-1:0];
                n_state  = S_FREEW;
            end
            S_FREEW: begin
                en_raddr = r_free[PW-1:0];
                n_state  = S_INS;
            end
            S_INS: begin
                // write new entry at free head, link to old chain head (r_cur)
                en_we    = 1'b1;
                en_waddr = r_free[PW-1:0];
                en_wdata = {ins_key, ins_val, r_cur};
                bh_we    = 1'b1;
                bh_wdata = r_free;
                n_free   = link_ok(rd_next);
                n_cnt    = r_cnt + LW'(1);
                n_stat   = ST_OK;
                n_state  = S_DONE;
            end
            S_RD: begin
                if (r_cur == NIL || r_steps == NIL) begin
                    n_stat  = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RDW;
                end
            end
            S_RDW: n_state = S_CMP;
            S_CMP: begin
                if (rd_key == r_key) begin
                    n_found = 1'b1;
                    n_fval  = 32'(rd_val);
                    n_stat  = ST_OK;
                    n_state = S_DONE;
                    if (r_cmd == CMD_REMOVE) begin
                        // unlink, then push onto free list
                        if (r_prev == NIL) begin
                            bh_we    = 1'b1;
                            bh_wdata = link_ok(rd_next);
                            en_we    = 1'b1;
                            en_wdata = {rd_key, rd_val, link_ok(r_free)};
                            n_free   = r_cur;
                            n_cnt    = (r_cnt != '0) ? r_cnt - LW'(1) : r_cnt;
                        end else begin
                            // rewrite prev with its saved key and value, free cur next
                            en_we    = 1'b1;
                            en_waddr = r_prev[PW-1:0];
                            en_wdata = {r_pkey, r_pval, link_ok(rd_next)};
                            n_state  = S_UNLINK;
                        end
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = link_ok(rd_next);
                    n_steps = r_steps + LW'(1);
                    n_state = S_RD;
                end
            end
            S_UNLINK: begin
                // finish remove of a non-head entry: cur now onto free list
                en_we    = 1'b1;
                en_wdata = {r_ckey, r_cval, link_ok(r_free)};
                n_free   = r_cur;
                n_cnt    = (r_cnt != '0) ? r_cnt - LW'(1) : r_cnt;
                n_state  = S_DONE;
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            r_pkey <= rd_key;
            r_pval <= rd_val;
            r_ckey <= rd_key;
            r_cval <= rd_val;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_mask   <= mask_of(9'd256);
            r_free   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else if (i_cfg_we) begin
            r_mask  <= mask_of(i_cfg_wdata);
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_free  <= '0;
            r_cnt   <= '0;
            r_ovalid <= n_ovalid;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_free   <= n_free;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        if (o_ready && i_valid) begin
            r_cmd   <= i_command;
            r_key   <= i_key[KW-1:0];
            r_val   <= i_value[VW-1:0];
            r_bkt   <= i_key[BW-1:0] & r_mask;
            r_fval  <= '0;
            r_found <= 1'b0;
            r_stat  <= ST_OK;
        end else begin
            r_fval  <= n_fval;
            r_found <= n_found;
            r_stat  <= n_stat;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_found_value = r_fval;
    assign o_found       = r_found;
    assign o_status      = r_stat;
    assign o_table_empty = (r_cnt == '0);

    `CHT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `CHT_ASSERT_NXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, o_valid)
    `CHT_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= NIL)
endmodule

FILE: rtl/core/cht_ram.sv
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
